// File: hdl/pbg_pkg.sv
// shared types, codes and widths for the pixel blend and gain unit
package pbg_pkg;

    localparam int TYPE_W  = 3;
    localparam int PIX_W   = 8;
    localparam int CH_W    = 2;
    localparam int GAIN_W  = 16;
    localparam int IDX_W   = 2;
    localparam int PROD_W  = GAIN_W + PIX_W;
    localparam int BLEND_W = 17;

    localparam logic [GAIN_W-1:0] GAIN_UNITY = 16'd256;
    localparam logic [PIX_W-1:0]  PIX_MAX    = 8'd255;

    typedef enum logic [TYPE_W-1:0] {
        MODE_MULTIPLY = 3'd0,
        MODE_SCREEN   = 3'd1,
        MODE_SUBTRACT = 3'd2,
        MODE_ADD      = 3'd3,
        MODE_OVERLAY  = 3'd4,
        MODE_SCALE    = 3'd5
    } mode_t;

    typedef enum logic [CH_W-1:0] {
        CH_BLUE  = 2'd0,
        CH_GREEN = 2'd1,
        CH_RED   = 2'd2
    } chan_t;

    typedef enum logic [IDX_W-1:0] {
        REG_GAIN_RED   = 2'd0,
        REG_GAIN_GREEN = 2'd1,
        REG_GAIN_BLUE  = 2'd2
    } reg_idx_t;

    typedef enum logic [1:0] {
        KIND_DIRECT,
        KIND_ROUND,
        KIND_ROUND_INV,
        KIND_SCALE
    } kind_t;

    typedef struct packed {
        logic [GAIN_W-1:0] red;
        logic [GAIN_W-1:0] green;
        logic [GAIN_W-1:0] blue;
    } gains_t;

    typedef struct packed {
        logic              valid;
        kind_t             kind;
        logic [PROD_W-1:0] prod;
        logic [PIX_W-1:0]  direct;
    } prod_stage_t;

endpackage

// File: hdl/pbg_if.sv
// valid/ready channel interfaces for requests and results
interface pbg_in_if;
    logic                         valid;
    logic                         ready;
    logic [pbg_pkg::TYPE_W-1:0]   req_type;
    logic [pbg_pkg::PIX_W-1:0]    top_value;
    logic [pbg_pkg::PIX_W-1:0]    bottom_value;
    logic [pbg_pkg::CH_W-1:0]     channel_index;

    modport source (
        output valid, req_type, top_value, bottom_value, channel_index,
        input  ready
    );
    modport sink (
        input  valid, req_type, top_value, bottom_value, channel_index,
        output ready
    );
endinterface

interface pbg_out_if;
    logic                      valid;
    logic                      ready;
    logic [pbg_pkg::PIX_W-1:0] blended_value;

    modport source (
        output valid, blended_value,
        input  ready
    );
    modport sink (
        input  valid, blended_value,
        output ready
    );
endinterface

// File: hdl/pixel_blend_and_gain_unit_core.sv
// top level of the pixel blend and gain unit
//
//  channel  | direction | payload
//  ---------+-----------+-----------------------------------------------------
//  req      | in        | req_type, top_value, bottom_value, channel_index
//  rsp      | out       | blended_value
//  cfg      | in        | cfg_we, cfg_index, cfg_wdata (gain red, green, blue)
//
//  one transfer per cycle in steady state while rsp is not stalled. stages are:
//  input register, multiplier into product register, divide by 255 into result
//  register. the 16x8 multiplier sets the critical path.
//  reset clears all valid flags and loads every gain with 1.0 (256).
//  a stalled result keeps the earlier stages filling; req.ready drops only
//  when all three stages hold data and rsp is stalled.
module pixel_blend_and_gain_unit_core (
    input  logic                        clk,
    input  logic                        rst_n,
    pbg_in_if.sink                      req,
    pbg_out_if.source                   rsp,
    input  logic                        cfg_we,
    input  logic [pbg_pkg::IDX_W-1:0]   cfg_index,
    input  logic [pbg_pkg::GAIN_W-1:0]  cfg_wdata
);

    pbg_pkg::gains_t       gains;
    pbg_pkg::prod_stage_t  prod_st;
    logic                  back_ready;

    pbg_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .gains     (gains)
    );

    pbg_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .gains    (gains),
        .dn_ready (back_ready),
        .prod_st  (prod_st)
    );

    pbg_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .prod_st  (prod_st),
        .up_ready (back_ready),
        .rsp      (rsp)
    );

    // a free output slot lets every stage move
    a_ready_when_out_free: assert property (
        @(posedge clk) disable iff (!rst_n)
        (!rsp.valid || rsp.ready) |-> req.ready
    ) else $error("request side stalled while result slot free");

    // a stalled result with a full product stage keeps that stage full
    a_prod_held: assert property (
        @(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.ready && prod_st.valid) |=> prod_st.valid
    ) else $error("product stage dropped while output stalled");

    a_gain_red_write: assert property (
        @(posedge clk) disable iff (!rst_n)
        (cfg_we && cfg_index == pbg_pkg::REG_GAIN_RED) |=> (gains.red == $past(cfg_wdata))
    ) else $error("red gain write lost");

endmodule

// File: hdl/pbg_cfg_regs.sv
// per-channel gain registers behind the configuration write port
module pbg_cfg_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [pbg_pkg::IDX_W-1:0]   cfg_index,
    input  logic [pbg_pkg::GAIN_W-1:0]  cfg_wdata,
    output pbg_pkg::gains_t             gains
);

    pbg_pkg::gains_t gains_reg;
    pbg_pkg::gains_t gains_next;

    always_comb
    begin
        gains_next = gains_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                pbg_pkg::REG_GAIN_RED:   gains_next.red   = cfg_wdata;
                pbg_pkg::REG_GAIN_GREEN: gains_next.green = cfg_wdata;
                pbg_pkg::REG_GAIN_BLUE:  gains_next.blue  = cfg_wdata;
                default:                 gains_next = gains_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gains_reg.red   <= pbg_pkg::GAIN_UNITY;
            gains_reg.green <= pbg_pkg::GAIN_UNITY;
            gains_reg.blue  <= pbg_pkg::GAIN_UNITY;
        end
        else
        begin
            gains_reg <= gains_next;
        end
    end

    assign gains = gains_reg;

endmodule

// File: hdl/pbg_front.sv
// input register, operand selection and the shared multiplier stage
module pbg_front (
    input  logic                  clk,
    input  logic                  rst_n,
    pbg_in_if.sink                req,
    input  pbg_pkg::gains_t       gains,
    input  logic                  dn_ready,
    output pbg_pkg::prod_stage_t  prod_st
);

    logic                         in_valid_reg;
    logic [pbg_pkg::TYPE_W-1:0]   mode_reg;
    logic [pbg_pkg::PIX_W-1:0]    top_reg;
    logic [pbg_pkg::PIX_W-1:0]    bottom_reg;
    logic [pbg_pkg::CH_W-1:0]     chan_reg;

    logic                         prod_valid_reg;
    pbg_pkg::kind_t               kind_reg;
    logic [pbg_pkg::PROD_W-1:0]   prod_reg;
    logic [pbg_pkg::PIX_W-1:0]    direct_reg;

    logic                         in_ready;
    logic                         prod_ready;

    pbg_pkg::kind_t               kind_next;
    logic [pbg_pkg::GAIN_W-1:0]   op_a;
    logic [pbg_pkg::PIX_W-1:0]    op_b;
    logic [pbg_pkg::PROD_W-1:0]   prod_next;
    logic [pbg_pkg::PIX_W-1:0]    direct_next;
    logic [pbg_pkg::PIX_W:0]      sum;
    logic [pbg_pkg::GAIN_W-1:0]   gain_sel;

    assign prod_ready = !prod_valid_reg || dn_ready;
    assign in_ready   = !in_valid_reg || prod_ready;
    assign req.ready  = in_ready;

    always_comb
    begin
        case (chan_reg)
            pbg_pkg::CH_BLUE:  gain_sel = gains.blue;
            pbg_pkg::CH_GREEN: gain_sel = gains.green;
            pbg_pkg::CH_RED:   gain_sel = gains.red;
            default:           gain_sel = pbg_pkg::GAIN_UNITY;
        endcase
    end

    assign sum = {1'b0, bottom_reg} + {1'b0, top_reg};

    always_comb
    begin
        kind_next   = pbg_pkg::KIND_DIRECT;
        op_a        = '0;
        op_b        = '0;
        direct_next = '0;
        case (mode_reg)
            pbg_pkg::MODE_MULTIPLY:
            begin
                kind_next = pbg_pkg::KIND_ROUND;
                op_a      = {8'd0, top_reg};
                op_b      = bottom_reg;
            end
            pbg_pkg::MODE_SCREEN:
            begin
                kind_next = pbg_pkg::KIND_ROUND_INV;
                op_a      = {8'd0, ~top_reg};
                op_b      = ~bottom_reg;
            end
            pbg_pkg::MODE_SUBTRACT:
            begin
                direct_next = (bottom_reg > top_reg) ? (bottom_reg - top_reg) : '0;
            end
            pbg_pkg::MODE_ADD:
            begin
                direct_next = sum[pbg_pkg::PIX_W] ? pbg_pkg::PIX_MAX
                                                  : sum[pbg_pkg::PIX_W-1:0];
            end
            pbg_pkg::MODE_OVERLAY:
            begin
                if (!bottom_reg[pbg_pkg::PIX_W-1])
                begin
                    kind_next = pbg_pkg::KIND_ROUND;
                    op_a      = {7'd0, top_reg, 1'b0};
                    op_b      = bottom_reg;
                end
                else
                begin
                    kind_next = pbg_pkg::KIND_ROUND_INV;
                    op_a      = {7'd0, ~top_reg, 1'b0};
                    op_b      = ~bottom_reg;
                end
            end
            pbg_pkg::MODE_SCALE:
            begin
                kind_next = pbg_pkg::KIND_SCALE;
                op_a      = gain_sel;
                op_b      = bottom_reg;
            end
            default:
            begin
                direct_next = '0;
            end
        endcase
    end

    assign prod_next = {8'd0, op_a} * {16'd0, op_b};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            prod_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= req.valid;
            end
            if (prod_ready)
            begin
                prod_valid_reg <= in_valid_reg;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_ready && req.valid)
        begin
            mode_reg   <= req.req_type;
            top_reg    <= req.top_value;
            bottom_reg <= req.bottom_value;
            chan_reg   <= req.channel_index;
        end
        if (prod_ready && in_valid_reg)
        begin
            kind_reg   <= kind_next;
            prod_reg   <= prod_next;
            direct_reg <= direct_next;
        end
    end

    assign prod_st.valid  = prod_valid_reg;
    assign prod_st.kind   = kind_reg;
    assign prod_st.prod   = prod_reg;
    assign prod_st.direct = direct_reg;

endmodule

// File: hdl/pbg_back.sv
// divide by 255 with rounding, scale saturation and the result register
module pbg_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  pbg_pkg::prod_stage_t  prod_st,
    output logic                  up_ready,
    pbg_out_if.source             rsp
);

    logic                          out_valid_reg;
    logic [pbg_pkg::PIX_W-1:0]     out_data_reg;
    logic [pbg_pkg::PIX_W-1:0]     out_data_next;
    logic                          out_ready;

    logic [pbg_pkg::BLEND_W:0]     biased;
    logic [pbg_pkg::BLEND_W:0]     est_sum;
    logic [9:0]                    quot_est;
    logic [pbg_pkg::BLEND_W:0]     quot_x255;
    logic [pbg_pkg::BLEND_W:0]     remain;
    logic [9:0]                    quot;

    assign out_ready = !out_valid_reg || rsp.ready;
    assign up_ready  = out_ready;

    // round(x/255) as floor((x+127)/255), estimate then one correction
    assign biased    = {1'b0, prod_st.prod[pbg_pkg::BLEND_W-1:0]} + 18'd127;
    assign est_sum   = biased + (biased >> 8) + (biased >> 16);
    assign quot_est  = est_sum[17:8];
    assign quot_x255 = {quot_est, 8'd0} - {8'd0, quot_est};
    assign remain    = biased - quot_x255;
    assign quot      = (remain >= 18'd255) ? (quot_est + 10'd1) : quot_est;

    always_comb
    begin
        case (prod_st.kind)
            pbg_pkg::KIND_DIRECT:    out_data_next = prod_st.direct;
            pbg_pkg::KIND_ROUND:     out_data_next = quot[pbg_pkg::PIX_W-1:0];
            pbg_pkg::KIND_ROUND_INV: out_data_next = ~quot[pbg_pkg::PIX_W-1:0];
            pbg_pkg::KIND_SCALE:
            begin
                out_data_next = (prod_st.prod[23:16] != 8'd0) ? pbg_pkg::PIX_MAX
                                                               : prod_st.prod[15:8];
            end
            default:                 out_data_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            out_valid_reg <= prod_st.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready && prod_st.valid)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.blended_value = out_data_reg;

endmodule

// File: test/tb_top.sv
// self-checking testbench for the pixel blend and gain unit core
module tb_top;

    typedef logic [pbg_pkg::TYPE_W-1:0] mode_val_t;
    typedef logic [pbg_pkg::PIX_W-1:0]  pix_val_t;
    typedef logic [pbg_pkg::CH_W-1:0]   chan_val_t;
    typedef logic [pbg_pkg::IDX_W-1:0]  idx_val_t;
    typedef logic [pbg_pkg::GAIN_W-1:0] gain_val_t;

    localparam mode_val_t MODE_UNUSED_LO = 3'd6;
    localparam mode_val_t MODE_UNUSED_HI = 3'd7;
    localparam chan_val_t CH_NONE        = 2'd3;
    localparam idx_val_t  REG_NONE       = 2'd3;
    localparam int STALL_LIMIT   = 5000;
    localparam int PIPE_LATENCY  = 3;

    class blend_scoreboard;
        gain_val_t gain_red;
        gain_val_t gain_green;
        gain_val_t gain_blue;
        pix_val_t  expected_q[$];
        int        errors;

        function new();
            gain_red   = pbg_pkg::GAIN_UNITY;
            gain_green = pbg_pkg::GAIN_UNITY;
            gain_blue  = pbg_pkg::GAIN_UNITY;
            errors     = 0;
        endfunction

        function void set_gain(idx_val_t idx, gain_val_t value);
            case (idx)
                pbg_pkg::REG_GAIN_RED:   gain_red   = value;
                pbg_pkg::REG_GAIN_GREEN: gain_green = value;
                pbg_pkg::REG_GAIN_BLUE:  gain_blue  = value;
                default: ;
            endcase
        endfunction

        function int unsigned round_div255(int unsigned x);
            return (2 * x + 255) / 510;
        endfunction

        function pix_val_t blend(mode_val_t mode, pix_val_t t, pix_val_t b, chan_val_t ch);
            int unsigned tv;
            int unsigned bv;
            int unsigned g;
            int unsigned r;
            tv = t;
            bv = b;
            r  = 0;
            case (mode)
                pbg_pkg::MODE_MULTIPLY: r = round_div255(tv * bv);
                pbg_pkg::MODE_SCREEN:   r = 255 - round_div255((255 - tv) * (255 - bv));
                pbg_pkg::MODE_SUBTRACT: r = (bv > tv) ? bv - tv : 0;
                pbg_pkg::MODE_ADD:      r = (bv + tv > 255) ? 255 : bv + tv;
                pbg_pkg::MODE_OVERLAY:
                begin
                    if (bv <= 127)
                        r = round_div255(2 * tv * bv);
                    else
                        r = 255 - round_div255(2 * (255 - tv) * (255 - bv));
                end
                pbg_pkg::MODE_SCALE:
                begin
                    case (ch)
                        pbg_pkg::CH_BLUE:  g = gain_blue;
                        pbg_pkg::CH_GREEN: g = gain_green;
                        pbg_pkg::CH_RED:   g = gain_red;
                        default:           g = pbg_pkg::GAIN_UNITY;
                    endcase
                    r = (bv * g) >> 8;
                    if (r > 255)
                        r = 255;
                end
                default: r = 0;
            endcase
            return r[pbg_pkg::PIX_W-1:0];
        endfunction

        function void note_request(mode_val_t mode, pix_val_t t, pix_val_t b, chan_val_t ch);
            expected_q.push_back(blend(mode, t, b, ch));
        endfunction

        task report_mismatch(string msg);
            $display("tb_top: mismatch at %0t: %s", $time, msg);
            errors++;
        endtask

        task check_result(pix_val_t value);
            pix_val_t want;
            if (expected_q.size() == 0)
            begin
                report_mismatch($sformatf("blended_value %0d with nothing pending", value));
            end
            else
            begin
                want = expected_q.pop_front();
                if (value !== want)
                    report_mismatch($sformatf("blended_value %0d, want %0d", value, want));
            end
        endtask

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    idx_val_t   cfg_index;
    gain_val_t  cfg_wdata;
    int         src_idle;
    int         snk_idle;
    int         quiet_cycles;

    pbg_in_if  req_ch ();
    pbg_out_if rsp_ch ();

    blend_scoreboard sb = new();

    pixel_blend_and_gain_unit_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // receiver back-pressure
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            rsp_ch.ready <= ($urandom_range(99, 0) >= snk_idle);
        end
    end

    // transfer monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
                sb.note_request(req_ch.req_type, req_ch.top_value,
                                req_ch.bottom_value, req_ch.channel_index);
            if (rsp_ch.valid && rsp_ch.ready)
                sb.check_result(rsp_ch.blended_value);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("tb_top: errors");
                $finish;
            end
        end
    end

    task automatic send_item(input mode_val_t mode, input pix_val_t t,
                             input pix_val_t b, input chan_val_t ch);
        while ($urandom_range(99, 0) < src_idle)
        begin
            @(negedge clk);
            req_ch.valid <= 1'b0;
        end
        @(negedge clk);
        req_ch.valid         <= 1'b1;
        req_ch.req_type      <= mode;
        req_ch.top_value     <= t;
        req_ch.bottom_value  <= b;
        req_ch.channel_index <= ch;
        do
            @(posedge clk);
        while (!req_ch.ready);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY + 1) @(posedge clk);
    endtask

    task automatic write_gain(input idx_val_t idx, input gain_val_t value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        sb.set_gain(idx, value);
    endtask

    function automatic gain_val_t pick_gain();
        case ($urandom_range(5, 0))
            0:       return '0;
            1:       return '1;
            2:       return pbg_pkg::GAIN_UNITY;
            3:       return gain_val_t'($urandom_range(1023, 0));
            default: return gain_val_t'($urandom_range(65535, 0));
        endcase
    endfunction

    function automatic pix_val_t pick_pixel();
        case ($urandom_range(7, 0))
            0:       return '0;
            1:       return pbg_pkg::PIX_MAX;
            2:       return pix_val_t'($urandom_range(128, 127));
            default: return pix_val_t'($urandom_range(255, 0));
        endcase
    endfunction

    task automatic send_random();
        mode_val_t mode;
        if ($urandom_range(19, 0) == 0)
            mode = $urandom_range(1, 0) ? MODE_UNUSED_HI : MODE_UNUSED_LO;
        else
            mode = mode_val_t'($urandom_range(pbg_pkg::MODE_SCALE, pbg_pkg::MODE_MULTIPLY));
        send_item(mode, pick_pixel(), pick_pixel(), chan_val_t'($urandom_range(3, 0)));
    endtask

    initial
    begin
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_index            = '0;
        cfg_wdata            = '0;
        req_ch.valid         = 1'b0;
        req_ch.req_type      = '0;
        req_ch.top_value     = '0;
        req_ch.bottom_value  = '0;
        req_ch.channel_index = '0;
        src_idle             = 0;
        snk_idle             = 0;
        quiet_cycles         = 0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // directed corners at reset gains
        write_gain(REG_NONE, 16'hFFFF);
        send_item(pbg_pkg::MODE_MULTIPLY, 8'd0,   8'd0,   pbg_pkg::CH_BLUE);
        send_item(pbg_pkg::MODE_MULTIPLY, 8'd255, 8'd255, pbg_pkg::CH_BLUE);
        send_item(pbg_pkg::MODE_MULTIPLY, 8'd128, 8'd77,  pbg_pkg::CH_BLUE);
        send_item(pbg_pkg::MODE_SCREEN,   8'd0,   8'd255, pbg_pkg::CH_GREEN);
        send_item(pbg_pkg::MODE_SCREEN,   8'd255, 8'd255, pbg_pkg::CH_GREEN);
        send_item(pbg_pkg::MODE_SCREEN,   8'd0,   8'd0,   pbg_pkg::CH_GREEN);
        send_item(pbg_pkg::MODE_SUBTRACT, 8'd200, 8'd10,  pbg_pkg::CH_RED);
        send_item(pbg_pkg::MODE_SUBTRACT, 8'd10,  8'd200, pbg_pkg::CH_RED);
        send_item(pbg_pkg::MODE_ADD,      8'd200, 8'd100, pbg_pkg::CH_RED);
        send_item(pbg_pkg::MODE_ADD,      8'd0,   8'd0,   pbg_pkg::CH_RED);
        send_item(pbg_pkg::MODE_OVERLAY,  8'd255, 8'd127, pbg_pkg::CH_BLUE);
        send_item(pbg_pkg::MODE_OVERLAY,  8'd0,   8'd128, pbg_pkg::CH_BLUE);
        send_item(pbg_pkg::MODE_OVERLAY,  8'd255, 8'd255, pbg_pkg::CH_BLUE);
        send_item(pbg_pkg::MODE_SCALE,    8'd255, 8'd255, pbg_pkg::CH_BLUE);
        send_item(pbg_pkg::MODE_SCALE,    8'd0,   8'd200, CH_NONE);
        send_item(MODE_UNUSED_LO, 8'd255, 8'd255, pbg_pkg::CH_RED);
        send_item(MODE_UNUSED_HI, 8'd255, 8'd255, CH_NONE);
        wait_idle();
        write_gain(pbg_pkg::REG_GAIN_RED,   16'hFFFF);
        write_gain(pbg_pkg::REG_GAIN_GREEN, 16'h0000);
        write_gain(pbg_pkg::REG_GAIN_BLUE,  16'h0001);
        write_gain(REG_NONE,                16'h0000);
        send_item(pbg_pkg::MODE_SCALE, 8'd0,   8'd255, pbg_pkg::CH_RED);
        send_item(pbg_pkg::MODE_SCALE, 8'd0,   8'd1,   pbg_pkg::CH_RED);
        send_item(pbg_pkg::MODE_SCALE, 8'd255, 8'd255, pbg_pkg::CH_GREEN);
        send_item(pbg_pkg::MODE_SCALE, 8'd0,   8'd255, pbg_pkg::CH_BLUE);
        send_item(pbg_pkg::MODE_SCALE, 8'd0,   8'd255, CH_NONE);

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    src_idle = 28;
                    snk_idle = 76;
                end
                1:
                begin
                    src_idle = 76;
                    snk_idle = 28;
                end
                default:
                begin
                    src_idle = 0;
                    snk_idle = 0;
                end
            endcase
            for (int burst = 0; burst < 3; burst++)
            begin
                wait_idle();
                write_gain(pbg_pkg::REG_GAIN_RED,   pick_gain());
                write_gain(pbg_pkg::REG_GAIN_GREEN, pick_gain());
                write_gain(pbg_pkg::REG_GAIN_BLUE,  pick_gain());
                if ($urandom_range(1, 0))
                    write_gain(REG_NONE, gain_val_t'($urandom_range(65535, 0)));
                repeat (89) send_random();
            end
        end

        wait_idle();
        repeat (4 * PIPE_LATENCY) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end
endmodule
